// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

// ----- design/fmcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Framed motor command receiver package
// Field widths, frame constants, register indexes, the result type and the
// CRC-8 byte update shared by the receiver and its channel interfaces.
// ----------------------------------------------------------------------------
package fmcr_pkg;

   localparam int WINDOW_LEN = 10;
   localparam int BYTE_W     = 8;
   localparam int CMD_W      = 16;
   localparam int TIMEOUT_W  = 16;
   localparam int PWM_W      = 8;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [BYTE_W-1:0] HEADER_HI  = 8'h15;
   localparam logic [BYTE_W-1:0] HEADER_LO  = 8'hEC;
   localparam logic [BYTE_W-1:0] TRAILER_HI = 8'h04;
   localparam logic [BYTE_W-1:0] TRAILER_LO = 8'hD2;
   localparam logic [BYTE_W-1:0] FRAME_TYPE = 8'h00;
   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1500;
   localparam logic [PWM_W-1:0]     PWM_MAX_RESET = 8'd225;
   localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

   typedef enum logic {
      MODE_BYTE = 1'b0,
      MODE_TICK = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT_MS = 1'b0,
      CSR_PWM_MAX    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                    frame_ok;
      logic                    link_lost;
      logic signed [CMD_W-1:0] left_command;
      logic signed [CMD_W-1:0] right_command;
      logic [PWM_W-1:0]        left_duty;
      logic                    left_reverse;
      logic [PWM_W-1:0]        right_duty;
      logic                    right_reverse;
   } rsp_payload_type;

   // One byte of CRC-8, most significant bit first.
   function automatic logic [BYTE_W-1:0] crc8_byte(logic [BYTE_W-1:0] crc,
                                                   logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         c = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ----- design/fmcr_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Carries received bytes and millisecond ticks into the receiver.
// ----------------------------------------------------------------------------
interface fmcr_req_if;
   import fmcr_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

// ----- design/fmcr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Carries one result per request transaction out of the receiver.
// ----------------------------------------------------------------------------
interface fmcr_rsp_if;
   import fmcr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    frame_ok;
   logic                    link_lost;
   logic signed [CMD_W-1:0] left_command;
   logic signed [CMD_W-1:0] right_command;
   logic [PWM_W-1:0]        left_duty;
   logic                    left_reverse;
   logic [PWM_W-1:0]        right_duty;
   logic                    right_reverse;

   modport source (output valid, output frame_ok, output link_lost, output left_command,
                   output right_command, output left_duty, output left_reverse,
                   output right_duty, output right_reverse, input ready);
   modport sink (input valid, input frame_ok, input link_lost, input left_command,
                 input right_command, input left_duty, input left_reverse,
                 input right_duty, input right_reverse, output ready);
endinterface

// ----- design/framed_motor_command_receiver.sv -----
// ----------------------------------------------------------------------------
// Framed motor command receiver
// Checks a ten-byte frame window with CRC-8, holds the left and right motor
// commands, times out the link and clamps the commands to duty and direction.
// ----------------------------------------------------------------------------
//
//   Channel       Direction  Carries
//   req_channel   in         mode, rx_byte
//   rsp_channel   out        frame_ok, link_lost, commands, duties, reverse bits
//   csr_*         in         timeout_ms (index 0), pwm_max (index 1)
//
// Each request transaction is processed in the cycle it is accepted and its
// result is registered; one transaction per cycle is sustained while rsp_channel
// takes results. A two-entry output stage (output register plus skid register)
// lets a request be taken while a result waits; req_channel.ready falls only
// when both entries are full. Synchronous reset clears the window, held
// commands, counter and output stage and loads the CSR reset values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_motor_command_receiver (
   input  logic                               clock,
   input  logic                               reset,
   fmcr_req_if.sink                           req_channel,
   fmcr_rsp_if.source                         rsp_channel,
   input  logic                               csr_write_enable,
   input  logic [fmcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fmcr_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import fmcr_pkg::*;

   logic [BYTE_W-1:0]    window_ff [WINDOW_LEN];
   logic [BYTE_W-1:0]    window_in [WINDOW_LEN];
   logic [CMD_W-1:0]     left_ff;
   logic [CMD_W-1:0]     left_in;
   logic [CMD_W-1:0]     right_ff;
   logic [CMD_W-1:0]     right_in;
   logic [TIMEOUT_W-1:0] elapsed_ff;
   logic [TIMEOUT_W-1:0] elapsed_in;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [PWM_W-1:0]     pwm_max_ff;

   rsp_payload_type      out_ff;
   rsp_payload_type      skid_ff;
   rsp_payload_type      result_in;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;

   logic                 accept;
   logic                 take;
   logic                 is_tick;
   logic [BYTE_W-1:0]    crc;
   logic                 frame_ok_in;
   logic                 lost_in;
   logic [PWM_W:0]       left_drive;
   logic [PWM_W:0]       right_drive;

   // Returns {reverse, duty} for a command clamped to +/- limit.
   function automatic logic [PWM_W:0] drive(logic [CMD_W-1:0] cmd, logic [PWM_W-1:0] limit);
      logic             neg;
      logic [CMD_W-1:0] mag;
      logic [PWM_W-1:0] duty;
      neg  = cmd[CMD_W-1];
      mag  = neg ? (~cmd + CMD_W'(1)) : cmd;
      duty = (mag > CMD_W'(limit)) ? limit : mag[PWM_W-1:0];
      return {neg && (limit != '0), duty};
   endfunction

   assign accept  = req_channel.valid && req_channel.ready;
   assign take    = rsp_channel.valid && rsp_channel.ready;
   assign is_tick = (req_channel.mode == MODE_TICK);

   assign req_channel.ready = !skid_valid_ff;

   always_comb begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[WINDOW_LEN-1] = req_channel.rx_byte;

      crc = CRC_INIT;
      for (int i = 2; i < 7; i++) begin
         crc = crc8_byte(crc, window_in[i]);
      end

      frame_ok_in = !is_tick
                    && (window_in[0] == HEADER_HI) && (window_in[1] == HEADER_LO)
                    && (window_in[8] == TRAILER_HI) && (window_in[9] == TRAILER_LO)
                    && (window_in[2] == FRAME_TYPE) && (crc == window_in[7]);

      left_in    = left_ff;
      right_in   = right_ff;
      elapsed_in = elapsed_ff;
      if (is_tick) begin
         if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + TIMEOUT_W'(1);
         end
      end else if (frame_ok_in) begin
         left_in    = {window_in[3], window_in[4]};
         right_in   = {window_in[5], window_in[6]};
         elapsed_in = '0;
      end

      lost_in = (elapsed_in > timeout_ff);
      if (lost_in) begin
         left_in  = '0;
         right_in = '0;
      end

      left_drive  = drive(left_in, pwm_max_ff);
      right_drive = drive(right_in, pwm_max_ff);

      result_in.frame_ok      = frame_ok_in;
      result_in.link_lost     = lost_in;
      result_in.left_command  = left_in;
      result_in.right_command = right_in;
      result_in.left_duty     = left_drive[PWM_W-1:0];
      result_in.left_reverse  = left_drive[PWM_W];
      result_in.right_duty    = right_drive[PWM_W-1:0];
      result_in.right_reverse = right_drive[PWM_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         left_ff       <= '0;
         right_ff      <= '0;
         elapsed_ff    <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         pwm_max_ff    <= PWM_MAX_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TIMEOUT_MS: timeout_ff <= csr_write_data[TIMEOUT_W-1:0];
               CSR_PWM_MAX:    pwm_max_ff <= csr_write_data[PWM_W-1:0];
               default: ;
            endcase
         end

         if (accept) begin
            if (!is_tick) begin
               window_ff <= window_in;
            end
            left_ff    <= left_in;
            right_ff   <= right_in;
            elapsed_ff <= elapsed_in;
         end

         if (skid_valid_ff) begin
            if (take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (accept) begin
            if (out_valid_ff && !take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (out_valid_ff && !take) begin
            skid_ff <= result_in;
         end else begin
            out_ff <= result_in;
         end
      end
   end

   assign rsp_channel.valid         = out_valid_ff;
   assign rsp_channel.frame_ok      = out_ff.frame_ok;
   assign rsp_channel.link_lost     = out_ff.link_lost;
   assign rsp_channel.left_command  = out_ff.left_command;
   assign rsp_channel.right_command = out_ff.right_command;
   assign rsp_channel.left_duty     = out_ff.left_duty;
   assign rsp_channel.left_reverse  = out_ff.left_reverse;
   assign rsp_channel.right_duty    = out_ff.right_duty;
   assign rsp_channel.right_reverse = out_ff.right_reverse;

   `ASSERT_NEVER(a_skid_needs_out, clock, reset, skid_valid_ff && !out_valid_ff, "skid entry without output entry")
   `ASSERT_PROP(a_frame_restarts_timer, clock, reset, accept && frame_ok_in |=> elapsed_ff == '0, "valid frame did not restart the timer")
   `ASSERT_NEVER(a_frame_not_lost, clock, reset, rsp_channel.valid && rsp_channel.frame_ok && rsp_channel.link_lost, "valid frame reported with link lost")
   `ASSERT_PROP(a_lost_clears_commands, clock, reset, rsp_channel.valid && rsp_channel.link_lost |-> rsp_channel.left_command == '0 && rsp_channel.right_command == '0, "commands not cleared on lost link")

endmodule
